### hw/rtl/aas_pkg.sv
// ----------------------------------------------------------------------------
// aas_pkg
// Shared widths, register indexes and request/result types of the
// analog absolute angle scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package aas_pkg;

    localparam int ADC_BITS  = 12;
    localparam int FRAC_BITS = 16;
    localparam int WIN_W     = FRAC_BITS + 1;
    localparam int FS_W      = 24;
    localparam int OFF_W     = 25;
    localparam int RAW_W     = OFF_W + 1;
    localparam int PROD_W    = WIN_W + FS_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = OFF_W;

    localparam logic [WIN_W-1:0] ONE_FRAC = WIN_W'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIR  = 3'd4;

    typedef struct packed {
        logic [ADC_BITS-1:0] sensor_sample;
        logic [ADC_BITS-1:0] rail_sample;
    } t_request;

    typedef struct packed {
        logic [FS_W-1:0] angle_pos;
        logic            fault;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/aas_frac_div.sv
// ----------------------------------------------------------------------------
// aas_frac_div
// Pipelined fractional divider, one quotient bit per stage. The starting
// remainder is below the divisor, so the quotient is a Q0.16 fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module aas_frac_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [aas_pkg::WIN_W-1:0]     i_rem,
    input  wire logic [aas_pkg::WIN_W-1:0]     i_div,
    output logic                               o_valid,
    output logic [aas_pkg::FRAC_BITS-1:0]      o_quot
);

    localparam int N = aas_pkg::FRAC_BITS;
    localparam int W = aas_pkg::WIN_W;

    logic         r_v   [N];
    logic [W-1:0] r_rem [N];
    logic [W-1:0] r_div [N];
    logic [N-1:0] r_q   [N];
    logic [W-1:0] n_rem [N];
    logic [N-1:0] n_q   [N];

    always_comb begin
        logic [W:0]   rem2;
        logic [W-1:0] src_rem;
        logic [W-1:0] src_div;
        logic [N-1:0] src_q;
        for (int k = 0; k < N; k++) begin
            src_rem = (k == 0) ? i_rem : r_rem[(k == 0) ? 0 : k - 1];
            src_div = (k == 0) ? i_div : r_div[(k == 0) ? 0 : k - 1];
            src_q   = (k == 0) ? '0    : r_q[(k == 0) ? 0 : k - 1];
            rem2 = {src_rem, 1'b0};
            if (rem2 >= {1'b0, src_div}) begin
                n_rem[k] = W'(rem2 - {1'b0, src_div});
                n_q[k]   = {src_q[N-2:0], 1'b1};
            end else begin
                n_rem[k] = rem2[W-1:0];
                n_q[k]   = {src_q[N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k < N; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_div[0] <= i_div;
        for (int k = 1; k < N; k++) begin
            r_div[k] <= r_div[k-1];
        end
        for (int k = 0; k < N; k++) begin
            r_rem[k] <= n_rem[k];
            r_q[k]   <= n_q[k];
        end
    end

    assign o_valid = r_v[N-1];
    assign o_quot  = r_q[N-1];

endmodule

`default_nettype wire

### hw/rtl/aas_wrap_mod.sv
// ----------------------------------------------------------------------------
// aas_wrap_mod
// Pipelined remainder unit: the magnitude of the offset position modulo the
// full scale, one dividend bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module aas_wrap_mod (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [aas_pkg::RAW_W-1:0]  i_mag,
    input  wire logic [aas_pkg::FS_W-1:0]   i_fs,
    output logic                            o_valid,
    output logic [aas_pkg::FS_W-1:0]        o_rem
);

    localparam int N = aas_pkg::RAW_W;
    localparam int W = aas_pkg::FS_W;

    logic         r_v   [N];
    logic [N-1:0] r_mag [N];
    logic [W-1:0] r_rem [N];
    logic [W-1:0] n_rem [N];

    always_comb begin
        logic [W:0]   rem2;
        logic [W-1:0] src_rem;
        logic [N-1:0] src_mag;
        for (int k = 0; k < N; k++) begin
            src_rem = (k == 0) ? '0    : r_rem[(k == 0) ? 0 : k - 1];
            src_mag = (k == 0) ? i_mag : r_mag[(k == 0) ? 0 : k - 1];
            rem2 = {src_rem, src_mag[N-1-k]};
            if (rem2 >= {1'b0, i_fs}) begin
                n_rem[k] = W'(rem2 - {1'b0, i_fs});
            end else begin
                n_rem[k] = rem2[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k < N; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag[0] <= i_mag;
        for (int k = 1; k < N; k++) begin
            r_mag[k] <= r_mag[k-1];
        end
        for (int k = 0; k < N; k++) begin
            r_rem[k] <= n_rem[k];
        end
    end

    assign o_valid = r_v[N-1];
    assign o_rem   = r_rem[N-1];

endmodule

`default_nettype wire

### hw/rtl/analog_absolute_angle_scaler.sv
// ----------------------------------------------------------------------------
// analog_absolute_angle_scaler
// Turns an encoder sample and a rail sample into a wrapped Q8.16 angle.
// Throughput is one request per cycle; busy never rises.
// The pipeline holds two 16-stage dividers and a 26-stage remainder unit.
// Synchronous active-low reset clears the pipeline and restores registers.
// ----------------------------------------------------------------------------
`default_nettype none

module analog_absolute_angle_scaler (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire aas_pkg::t_request              i_request,
    output logic                                o_busy,
    input  wire logic                           i_cfg_we,
    input  wire logic [aas_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [aas_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    output logic                                o_strobe,
    output aas_pkg::t_result                    o_result
);

    localparam int WW = aas_pkg::WIN_W;
    localparam int FW = aas_pkg::FS_W;
    localparam int RW = aas_pkg::RAW_W;
    localparam int DL = aas_pkg::FRAC_BITS;
    localparam int ML = aas_pkg::RAW_W;

    logic [WW-1:0]                  r_window_low;
    logic [WW-1:0]                  r_window_high;
    logic [FW-1:0]                  r_full_scale;
    logic [aas_pkg::OFF_W-1:0]      r_zero_offset;
    logic                           r_invert_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_low  <= '0;
            r_window_high <= aas_pkg::ONE_FRAC;
            r_full_scale  <= FW'(aas_pkg::ONE_FRAC);
            r_zero_offset <= '0;
            r_invert_dir  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aas_pkg::REG_WINDOW_LOW:  r_window_low  <= i_cfg_data[WW-1:0];
                aas_pkg::REG_WINDOW_HIGH: r_window_high <= i_cfg_data[WW-1:0];
                aas_pkg::REG_FULL_SCALE:  r_full_scale  <= i_cfg_data[FW-1:0];
                aas_pkg::REG_ZERO_OFFSET: r_zero_offset <= i_cfg_data;
                aas_pkg::REG_INVERT_DIR:  r_invert_dir  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    logic [WW-1:0] lo;
    logic [WW-1:0] hi;
    assign lo = (r_window_low  > aas_pkg::ONE_FRAC) ? aas_pkg::ONE_FRAC : r_window_low;
    assign hi = (r_window_high > aas_pkg::ONE_FRAC) ? aas_pkg::ONE_FRAC : r_window_high;

    assign o_busy = 1'b0;

    // Stage A: register the request.
    logic                          r_a_valid;
    logic [aas_pkg::ADC_BITS-1:0]  r_a_sensor;
    logic [aas_pkg::ADC_BITS-1:0]  r_a_rail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_sensor <= i_request.sensor_sample;
        r_a_rail   <= i_request.rail_sample;
    end

    logic a_fault;
    logic a_sat;
    assign a_fault = (r_a_rail == '0) || (hi == lo);
    assign a_sat   = r_a_sensor >= r_a_rail;

    logic                         d1_valid;
    logic [aas_pkg::FRAC_BITS-1:0] d1_quot;

    aas_frac_div u_ratio_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_valid),
        .i_rem   (WW'(r_a_sensor)),
        .i_div   (WW'(r_a_rail)),
        .o_valid (d1_valid),
        .o_quot  (d1_quot)
    );

    logic r_t1_fault [DL];
    logic r_t1_sat   [DL];

    always_ff @(posedge i_clk) begin
        r_t1_fault[0] <= a_fault;
        r_t1_sat[0]   <= a_sat;
        for (int k = 1; k < DL; k++) begin
            r_t1_fault[k] <= r_t1_fault[k-1];
            r_t1_sat[k]   <= r_t1_sat[k-1];
        end
    end

    // Stage B: clamp to the window and set up the renormalizing division.
    logic [WW-1:0] b_ratio;
    logic [WW-1:0] b_clamp;
    logic [WW-1:0] b_num;
    logic [WW-1:0] b_den;
    logic          b_full;

    always_comb begin
        b_ratio = r_t1_sat[DL-1] ? aas_pkg::ONE_FRAC : WW'(d1_quot);
        if (b_ratio < lo) begin
            b_clamp = lo;
        end else if (b_ratio > hi) begin
            b_clamp = hi;
        end else begin
            b_clamp = b_ratio;
        end
        b_num  = b_clamp - lo;
        b_den  = hi - lo;
        b_full = (hi < lo) || (b_num == b_den);
    end

    logic          r_b_valid;
    logic [WW-1:0] r_b_num;
    logic [WW-1:0] r_b_den;
    logic          r_b_full;
    logic          r_b_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_num   <= b_num;
        r_b_den   <= b_den;
        r_b_full  <= b_full;
        r_b_fault <= r_t1_fault[DL-1];
    end

    logic                          d2_valid;
    logic [aas_pkg::FRAC_BITS-1:0] d2_quot;

    aas_frac_div u_norm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_valid),
        .i_rem   (r_b_num),
        .i_div   (r_b_den),
        .o_valid (d2_valid),
        .o_quot  (d2_quot)
    );

    logic r_t2_fault [DL];
    logic r_t2_full  [DL];

    always_ff @(posedge i_clk) begin
        r_t2_fault[0] <= r_b_fault;
        r_t2_full[0]  <= r_b_full;
        for (int k = 1; k < DL; k++) begin
            r_t2_fault[k] <= r_t2_fault[k-1];
            r_t2_full[k]  <= r_t2_full[k-1];
        end
    end

    // Stage C: scale by the full range.
    logic [WW-1:0] c_norm;
    assign c_norm = r_t2_full[DL-1] ? aas_pkg::ONE_FRAC : WW'(d2_quot);

    logic                        r_c_valid;
    logic [aas_pkg::PROD_W-1:0]  r_c_prod;
    logic                        r_c_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_prod  <= aas_pkg::PROD_W'(c_norm) * aas_pkg::PROD_W'(r_full_scale);
        r_c_fault <= r_t2_fault[DL-1];
    end

    // Stage D: subtract the zero offset and split sign and magnitude.
    logic [FW-1:0] d_scaled;
    logic [RW-1:0] d_raw;
    logic          d_neg;
    logic [RW-1:0] d_mag;

    always_comb begin
        d_scaled = r_c_prod[aas_pkg::FRAC_BITS +: FW];
        d_raw    = {2'b00, d_scaled} - {r_zero_offset[aas_pkg::OFF_W-1], r_zero_offset};
        d_neg    = d_raw[RW-1];
        d_mag    = d_neg ? RW'(-d_raw) : d_raw;
    end

    logic          r_d_valid;
    logic [RW-1:0] r_d_mag;
    logic          r_d_neg;
    logic          r_d_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_mag   <= d_mag;
        r_d_neg   <= d_neg;
        r_d_fault <= r_c_fault;
    end

    logic          m_valid;
    logic [FW-1:0] m_rem;

    aas_wrap_mod u_wrap_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_valid),
        .i_mag   (r_d_mag),
        .i_fs    (r_full_scale),
        .o_valid (m_valid),
        .o_rem   (m_rem)
    );

    logic r_t3_fault [ML];
    logic r_t3_neg   [ML];

    always_ff @(posedge i_clk) begin
        r_t3_fault[0] <= r_d_fault;
        r_t3_neg[0]   <= r_d_neg;
        for (int k = 1; k < ML; k++) begin
            r_t3_fault[k] <= r_t3_fault[k-1];
            r_t3_neg[k]   <= r_t3_neg[k-1];
        end
    end

    // Stage E: true modulus, direction and special cases.
    aas_pkg::t_result e_res;
    logic [FW-1:0]    e_wrap;

    always_comb begin
        e_wrap = (r_t3_neg[ML-1] && (m_rem != '0)) ? r_full_scale - m_rem : m_rem;
        e_res.fault     = 1'b0;
        e_res.angle_pos = r_invert_dir ? r_full_scale - e_wrap : e_wrap;
        if (r_t3_fault[ML-1]) begin
            e_res.fault     = 1'b1;
            e_res.angle_pos = '0;
        end else if (r_full_scale == '0) begin
            e_res.angle_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= e_res;
    end

endmodule

`default_nettype wire
